// ----- hdl/hlfr_pkg.sv -----
// ----------------------------------------------------------------------------
// hlfr_pkg
// Shared types and constants for the header/length frame receiver: default
// geometry, command and register codes, phase and abort cause encodings, and
// the structs that pass configuration and results between the submodules.
// ----------------------------------------------------------------------------
package hlfr_pkg;

	// Default geometry of a frame.
	localparam int unsigned HEADER_LEN_DEF = 2;
	localparam int unsigned MAX_FRAME_DEF  = 256;

	// Field widths fixed by the stream format.
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned INDEX_W   = 12;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned TICK_W    = 16;
	localparam int unsigned SYNC_W    = 32;
	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned M_TDATA_W = 24;
	localparam int unsigned M_TUSER_W = 3;

	// Input item kinds carried on s_tuser.
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Register selects (paddr bit 2).
	localparam logic REG_SYNC    = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CAUSE_NONE     = 2'd0,
		CAUSE_MISMATCH = 2'd1,
		CAUSE_TIMEOUT  = 2'd2,
		CAUSE_ZERO     = 2'd3
	} cause_t;

	typedef struct packed {
		logic [SYNC_W-1:0] sync_pattern;
		logic [TICK_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  frame_byte;
		logic [INDEX_W-1:0] byte_index;
		logic               last;
		logic               aborted;
		cause_t             abort_cause;
	} result_t;

endpackage

// ----- hdl/hlfr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hlfr_cfg_regs
// APB register bank: sync pattern at offset 0x0, timeout in ticks at 0x4.
// Writes land on the access phase; reads return the stored values.
// ----------------------------------------------------------------------------
module hlfr_cfg_regs
	import hlfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [SYNC_W-1:0] sync_pattern_q;
	logic [TICK_W-1:0] timeout_ticks_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q  <= '0;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_SYNC:    sync_pattern_q  <= pwdata;
				REG_TIMEOUT: timeout_ticks_q <= pwdata[TICK_W-1:0];
				default:     sync_pattern_q  <= sync_pattern_q;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (paddr[2])
			REG_SYNC:    prdata = sync_pattern_q;
			REG_TIMEOUT: prdata = {16'd0, timeout_ticks_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg.sync_pattern  = sync_pattern_q;
	assign cfg.timeout_ticks = timeout_ticks_q;

endmodule

// ----- hdl/hlfr_core.sv -----
// ----------------------------------------------------------------------------
// hlfr_core
// Frame parser state machine. Each accepted item (byte or tick) updates the
// phase, position, remaining payload, length high byte and tick counter and
// produces at most one result for the output buffer.
// ----------------------------------------------------------------------------
module hlfr_core
	import hlfr_pkg::*;
#(
	parameter int unsigned HEADER_LEN = HEADER_LEN_DEF,
	parameter int unsigned MAX_FRAME  = MAX_FRAME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              accept,
	input  logic              cmd,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              res_valid,
	output result_t           res
);

	localparam logic [INDEX_W-1:0] HDR_LEN_IDX = INDEX_W'(HEADER_LEN);
	localparam logic [LEN_W-1:0]   PAYLOAD_CAP = LEN_W'(MAX_FRAME - HEADER_LEN - 2);

	phase_t             phase_q, phase_d;
	logic [INDEX_W-1:0] position_q, position_d;
	logic [LEN_W-1:0]   payload_left_q, payload_left_d;
	logic [BYTE_W-1:0]  length_high_q, length_high_d;
	logic [TICK_W-1:0]  tick_count_q, tick_count_d;

	// Effective state: an unused phase code reads as the idle state.
	logic               ph_bad;
	phase_t             ph;
	logic [INDEX_W-1:0] pos;
	logic [LEN_W-1:0]   pl;
	logic [BYTE_W-1:0]  lh;
	logic [TICK_W-1:0]  tc;

	logic               idle_hdr;
	logic [TICK_W-1:0]  tick_inc;
	logic [TICK_W-1:0]  tick_lim;
	logic               timeout_hit;
	logic [BYTE_W-1:0]  expect_byte;
	logic               hdr_match;
	logic [INDEX_W-1:0] pos_inc;
	logic [LEN_W-1:0]   len_raw;
	logic [LEN_W-1:0]   len_clamped;

	assign ph_bad = (phase_q != PH_HEADER) && (phase_q != PH_LENGTH) &&
	                (phase_q != PH_PAYLOAD);
	assign ph     = ph_bad ? PH_HEADER : phase_q;
	assign pos    = ph_bad ? '0 : position_q;
	assign pl     = ph_bad ? '0 : payload_left_q;
	assign lh     = ph_bad ? '0 : length_high_q;
	assign tc     = ph_bad ? '0 : tick_count_q;

	// Shared datapath terms.
	assign idle_hdr    = (ph == PH_HEADER) && (pos == '0);
	assign tick_inc    = (tc != '1) ? tc + 1'b1 : tc;
	assign tick_lim    = (cfg.timeout_ticks == '0) ? TICK_W'(1) : cfg.timeout_ticks;
	assign timeout_hit = tick_inc >= tick_lim;
	assign expect_byte = cfg.sync_pattern[{pos[1:0], 3'b000} +: BYTE_W];
	assign hdr_match   = rx_byte == expect_byte;
	assign pos_inc     = pos + 1'b1;
	assign len_raw     = {lh, rx_byte};
	assign len_clamped = (len_raw > PAYLOAD_CAP) ? PAYLOAD_CAP : len_raw;

	// Next-state logic.
	always_comb begin
		phase_d        = ph;
		position_d     = pos;
		payload_left_d = pl;
		length_high_d  = lh;
		tick_count_d   = tc;
		if (accept) begin
			if (cmd == CMD_TICK) begin
				if (!idle_hdr) begin
					if (timeout_hit) begin
						phase_d        = PH_HEADER;
						position_d     = '0;
						payload_left_d = '0;
						length_high_d  = '0;
						tick_count_d   = '0;
					end else begin
						tick_count_d = tick_inc;
					end
				end
			end else begin
				unique case (ph)
					PH_HEADER: begin
						if (pos >= HDR_LEN_IDX || (!hdr_match && pos != '0)) begin
							phase_d        = PH_HEADER;
							position_d     = '0;
							payload_left_d = '0;
							length_high_d  = '0;
							tick_count_d   = '0;
						end else if (hdr_match) begin
							position_d   = pos_inc;
							tick_count_d = '0;
							if (pos_inc >= HDR_LEN_IDX) begin
								phase_d = PH_LENGTH;
							end
						end
					end
					PH_LENGTH: begin
						if (pos == HDR_LEN_IDX) begin
							length_high_d = rx_byte;
							position_d    = pos_inc;
						end else if (len_raw == '0) begin
							phase_d        = PH_HEADER;
							position_d     = '0;
							payload_left_d = '0;
							length_high_d  = '0;
							tick_count_d   = '0;
						end else begin
							payload_left_d = len_clamped;
							position_d     = pos_inc;
							phase_d        = PH_PAYLOAD;
							tick_count_d   = '0;
						end
					end
					PH_PAYLOAD: begin
						if (pl <= LEN_W'(1)) begin
							phase_d        = PH_HEADER;
							position_d     = '0;
							payload_left_d = '0;
							length_high_d  = '0;
							tick_count_d   = '0;
						end else begin
							payload_left_d = pl - 1'b1;
							position_d     = pos_inc;
						end
					end
					default: begin
						phase_d = PH_HEADER;
					end
				endcase
			end
		end
	end

	// Result logic.
	always_comb begin
		res_valid       = 1'b0;
		res.frame_byte  = '0;
		res.byte_index  = '0;
		res.last        = 1'b0;
		res.aborted     = 1'b0;
		res.abort_cause = CAUSE_NONE;
		if (accept) begin
			if (cmd == CMD_TICK) begin
				if (!idle_hdr && timeout_hit) begin
					res_valid       = 1'b1;
					res.aborted     = 1'b1;
					res.abort_cause = CAUSE_TIMEOUT;
				end
			end else begin
				unique case (ph)
					PH_HEADER: begin
						if (pos < HDR_LEN_IDX) begin
							if (hdr_match) begin
								res_valid      = 1'b1;
								res.frame_byte = rx_byte;
								res.byte_index = pos;
							end else if (pos != '0) begin
								res_valid       = 1'b1;
								res.aborted     = 1'b1;
								res.abort_cause = CAUSE_MISMATCH;
							end
						end
					end
					PH_LENGTH: begin
						res_valid = 1'b1;
						if (pos != HDR_LEN_IDX && len_raw == '0) begin
							res.aborted     = 1'b1;
							res.abort_cause = CAUSE_ZERO;
						end else begin
							res.frame_byte = rx_byte;
							res.byte_index = pos;
						end
					end
					PH_PAYLOAD: begin
						res_valid      = 1'b1;
						res.frame_byte = rx_byte;
						res.byte_index = pos;
						res.last       = pl <= LEN_W'(1);
					end
					default: begin
						res_valid = 1'b0;
					end
				endcase
			end
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			position_q     <= '0;
			payload_left_q <= '0;
			length_high_q  <= '0;
			tick_count_q   <= '0;
		end else begin
			phase_q        <= phase_d;
			position_q     <= position_d;
			payload_left_q <= payload_left_d;
			length_high_q  <= length_high_d;
			tick_count_q   <= tick_count_d;
		end
	end

endmodule

// ----- hdl/hlfr_out_buf.sv -----
// ----------------------------------------------------------------------------
// hlfr_out_buf
// Two-entry output buffer: a result register plus a skid register, so the
// parser can still hand over a result after the sink stalls.
// ----------------------------------------------------------------------------
module hlfr_out_buf
	import hlfr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    pop;

	assign pop      = out_valid_q & out_ready;
	assign in_ready = ~skid_valid_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- hdl/header_length_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// header_length_frame_receiver
// Parses a byte stream into sync-header, length-prefixed frames, emitting
// every frame byte with its index, a last mark, and abort results.
// ----------------------------------------------------------------------------
// The receiver takes one item per clock on the s_ stream, while s_tready is
// high: a received byte or a time tick, chosen by s_tuser. Each item is parsed
// in the cycle it is taken; its result, if any, is registered in the output
// buffer before it appears on the m_ stream. The two-entry buffer lets input
// keep flowing after the sink stalls; s_tready drops only while both entries
// are full. A frame is HEADER_LEN sync bytes matched against sync_pattern
// (first byte in the low octet), a big-endian 16-bit length clamped to
// MAX_FRAME - HEADER_LEN - 2, then the payload; the final payload byte carries
// m_tlast. The user must write configuration registers over APB only while
// the stream is idle; the block itself does not enforce this.
module header_length_frame_receiver
	import hlfr_pkg::*;
#(
	parameter int unsigned HEADER_LEN = HEADER_LEN_DEF,
	parameter int unsigned MAX_FRAME  = MAX_FRAME_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// APB configuration port.
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// Input stream.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [7:0] rx_byte
	input  logic                 s_tuser,  // [0] cmd
	// Output stream.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [7:0] frame_byte, [19:8] byte_index
	output logic [M_TUSER_W-1:0] m_tuser,  // [0] aborted, [2:1] abort_cause
	output logic                 m_tlast   // last
);

	cfg_t    cfg;
	logic    accept;
	logic    res_valid;
	result_t res;
	result_t out_res;

	hlfr_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign accept = s_tvalid & s_tready;

	hlfr_core #(
		.HEADER_LEN (HEADER_LEN),
		.MAX_FRAME  (MAX_FRAME)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.cmd       (s_tuser),
		.rx_byte   (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	hlfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	// Pack the result onto the output stream.
	assign m_tdata = {4'd0, out_res.byte_index, out_res.frame_byte};
	assign m_tuser = {out_res.abort_cause, out_res.aborted};
	assign m_tlast = out_res.last;

endmodule
